// ----- hw/rtl/pmid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_pkg
// Shared widths, register codes and the square root cell word.
// ----------------------------------------------------------------------------
package pmid_pkg;

    localparam int SIZE_W    = 23;
    localparam int DIMS_W    = 2;
    localparam int ROOT_W    = 25;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int LANE_LAT  = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [SIZE_W-1:0] BOX_RESET  = SIZE_W'(40960);
    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(1);

    typedef enum logic [1:0] {
        REG_BOX_X  = 2'd0,
        REG_BOX_Y  = 2'd1,
        REG_BOX_Z  = 2'd2,
        REG_ACTIVE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   rad;
    } pmid_sqrt_t;

endpackage

// ----- hw/rtl/pmid_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_axis
// One axis lane: difference, single periodic wrap, magnitude, clipped square.
// ----------------------------------------------------------------------------
module pmid_axis #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [COORD_WIDTH-1:0]    a,
    input  logic signed [COORD_WIDTH-1:0]    b,
    input  logic [pmid_pkg::SIZE_W-1:0]      size,
    output logic [pmid_pkg::SQ_W-1:0]        sq
);
    import pmid_pkg::*;

    localparam int CMP_W = ((COORD_WIDTH + 2 > SIZE_W + 1) ? COORD_WIDTH + 2 : SIZE_W + 1) + 1;
    localparam int EXT_W = (CMP_W > ROOT_W + 1) ? CMP_W : ROOT_W + 1;

    logic signed [CMP_W-1:0] diff_reg,    diff_next;
    logic signed [CMP_W-1:0] wrap_reg,    wrap_next;
    logic [ROOT_W-1:0]       mag_reg,     mag_next;
    logic                    sat_reg,     sat_next;
    logic [SQ_W-1:0]         sq_reg,      sq_next;

    logic signed [CMP_W-1:0] twice;
    logic signed [CMP_W-1:0] size_s;
    logic [CMP_W-1:0]        mag_full;
    logic [EXT_W-1:0]        mag_ext;

    always_comb
    begin
        diff_next = en ? (CMP_W'(a) - CMP_W'(b)) : '0;

        twice  = diff_reg <<< 1;
        size_s = $signed(CMP_W'(size));
        if (twice > size_s)
            wrap_next = diff_reg - size_s;
        else if (twice < -size_s)
            wrap_next = diff_reg + size_s;
        else
            wrap_next = diff_reg;

        mag_full = wrap_reg[CMP_W-1] ? $unsigned(-wrap_reg) : $unsigned(wrap_reg);
        mag_ext  = EXT_W'(mag_full);
        sat_next = mag_ext > EXT_W'({ROOT_W{1'b1}});
        mag_next = mag_ext[ROOT_W-1:0];

        sq_next = sat_reg ? {SQ_W{1'b1}} : SQ_W'(mag_reg * mag_reg);
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        wrap_reg <= wrap_next;
        mag_reg  <= mag_next;
        sat_reg  <= sat_next;
        sq_reg   <= sq_next;
    end

    assign sq = sq_reg;

endmodule

// ----- hw/rtl/pmid_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_sqrt_cell
// One bit of the restoring square root; hands its word to the next cell.
// ----------------------------------------------------------------------------
module pmid_sqrt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  pmid_pkg::pmid_sqrt_t word_in,
    output logic                 valid_out,
    output pmid_pkg::pmid_sqrt_t word_out
);
    import pmid_pkg::*;

    logic       valid_reg;
    pmid_sqrt_t word_reg, word_next;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        cur   = {word_in.rem[REM_W-3:0], word_in.rad[SQ_W-1 -: 2]};
        trial = REM_W'({word_in.root, 2'b01});
        word_next.rad = word_in.rad << 2;
        if (cur >= trial)
        begin
            word_next.rem  = cur - trial;
            word_next.root = {word_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            word_next.rem  = cur;
            word_next.root = {word_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

// ----- hw/rtl/periodic_min_image_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_min_image_distance
// Minimum-image distance of two points in a periodic box, Q12.12.
// Pipeline from start to done: 4 lane stages, 1 sum, 25 root cells.
// Throughput: one word per cycle; busy stays low, the cell chain is fully pipelined.
// Reset clears the valid chain and loads box sizes 40960 and one active axis.
// Results are strobed by done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module periodic_min_image_distance #(
    parameter int MAX_DIMS    = 3,
    parameter int COORD_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmid_pkg::ADDR_W-1:0]     paddr,
    input  logic [pmid_pkg::DATA_W-1:0]     pwdata,
    output logic [pmid_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,

    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   point_a_x,
    input  logic signed [COORD_WIDTH-1:0]   point_a_y,
    input  logic signed [COORD_WIDTH-1:0]   point_a_z,
    input  logic signed [COORD_WIDTH-1:0]   point_b_x,
    input  logic signed [COORD_WIDTH-1:0]   point_b_y,
    input  logic signed [COORD_WIDTH-1:0]   point_b_z,

    output logic                            done,
    output logic [pmid_pkg::ROOT_W-1:0]     distance
);
    import pmid_pkg::*;

    logic [SIZE_W-1:0] box_reg [3];
    logic [DIMS_W-1:0] active_dims_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    logic signed [COORD_WIDTH-1:0] pa [3];
    logic signed [COORD_WIDTH-1:0] pb [3];
    logic [SQ_W-1:0]               sq [MAX_DIMS];

    logic [LANE_LAT:0]  front_vld_reg;
    logic [SQ_W-1:0]    sum_reg, sum_next;
    logic [SQ_W+1:0]    sum_full;

    pmid_sqrt_t         stage [ROOT_W+1];
    logic [ROOT_W:0]    stage_vld;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg[0]      <= BOX_RESET;
            box_reg[1]      <= BOX_RESET;
            box_reg[2]      <= BOX_RESET;
            active_dims_reg <= DIMS_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BOX_X:  box_reg[0]      <= pwdata[SIZE_W-1:0];
                REG_BOX_Y:  box_reg[1]      <= pwdata[SIZE_W-1:0];
                REG_BOX_Z:  box_reg[2]      <= pwdata[SIZE_W-1:0];
                REG_ACTIVE: active_dims_reg <= pwdata[DIMS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BOX_X:  prdata = DATA_W'(box_reg[0]);
            REG_BOX_Y:  prdata = DATA_W'(box_reg[1]);
            REG_BOX_Z:  prdata = DATA_W'(box_reg[2]);
            REG_ACTIVE: prdata = DATA_W'(active_dims_reg);
            default:    prdata = '0;
        endcase
    end

    assign pa[0] = point_a_x;
    assign pa[1] = point_a_y;
    assign pa[2] = point_a_z;
    assign pb[0] = point_b_x;
    assign pb[1] = point_b_y;
    assign pb[2] = point_b_z;

    genvar j;
    generate
        for (j = 0; j < MAX_DIMS; j++)
        begin : g_axis
            pmid_axis #(
                .COORD_WIDTH (COORD_WIDTH)
            ) u_axis (
                .clk  (clk),
                .en   (active_dims_reg > DIMS_W'(j)),
                .a    (pa[j]),
                .b    (pb[j]),
                .size (box_reg[j]),
                .sq   (sq[j])
            );
        end
    endgenerate

    // saturate at the largest radicand whose root still fits the output
    always_comb
    begin
        sum_full = '0;
        for (int k = 0; k < MAX_DIMS; k++)
            sum_full = sum_full + (SQ_W+2)'(sq[k]);
        sum_next = (|sum_full[SQ_W+1:SQ_W]) ? {SQ_W{1'b1}} : sum_full[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= '0;
        else
            front_vld_reg <= {front_vld_reg[LANE_LAT-1:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign stage_vld[0]  = front_vld_reg[LANE_LAT];
    assign stage[0].rem  = '0;
    assign stage[0].root = '0;
    assign stage[0].rad  = sum_reg;

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_root
            pmid_sqrt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .valid_in  (stage_vld[i]),
                .word_in   (stage[i]),
                .valid_out (stage_vld[i+1]),
                .word_out  (stage[i+1])
            );
        end
    endgenerate

    assign done     = stage_vld[ROOT_W];
    assign distance = stage[ROOT_W].root;

endmodule
